// ----- src/mpmd_pkg.sv -----
`default_nettype none

package mpmd_pkg;

  // Patch geometry; the sorted store holds one full patch.
  localparam int MAX_PATCH_RADIUS = 2;
  localparam int PATCH_SIDE       = 2 * MAX_PATCH_RADIUS + 1;
  localparam int STORE_DEPTH      = PATCH_SIDE * PATCH_SIDE;
  localparam int IDX_W            = $clog2(STORE_DEPTH);
  localparam int CNT_W            = $clog2(STORE_DEPTH + 1);

  // Field widths
  localparam int DEPTH_W  = 16;
  localparam int MED_W    = 17;
  localparam int STAT_W   = 2;
  localparam int COORD_W  = 12;
  localparam int SIDE_CFG_W = 13;
  localparam int RAD_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int OUT_DATA_W = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_SEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_POINT = 2'd1;
  localparam logic [STAT_W-1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_DEPTH = 2'd3;

  typedef struct packed {
    logic                  point_sel;
    logic [COORD_W-1:0]    point_x;
    logic [COORD_W-1:0]    point_y;
    logic [SIDE_CFG_W-1:0] frame_w;
    logic [SIDE_CFG_W-1:0] frame_h;
    logic [RAD_W-1:0]      radius;
  } cfg_t;

  typedef struct packed {
    logic take;       // input word accepted this cycle
    logic seek_clr;   // restart the median seek
    logic seek_step;  // drop the lowest stored sample
    logic out_load;   // latch the result, clear the store
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_target;  // lowest cell now holds the lower middle sample
    logic out_free;   // output register can take a result
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- src/mpmd_regs.sv -----
`default_nettype none

module mpmd_regs (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [mpmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [mpmd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output mpmd_pkg::cfg_t                      cfg
);
  import mpmd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_POINT_SEL: cfg_nxt.point_sel = cfg_wdata[0];
        REG_POINT_X:   cfg_nxt.point_x   = cfg_wdata[COORD_W-1:0];
        REG_POINT_Y:   cfg_nxt.point_y   = cfg_wdata[COORD_W-1:0];
        REG_FRAME_W:   cfg_nxt.frame_w   = cfg_wdata[SIDE_CFG_W-1:0];
        REG_FRAME_H:   cfg_nxt.frame_h   = cfg_wdata[SIDE_CFG_W-1:0];
        REG_RADIUS:    cfg_nxt.radius    = cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.point_sel <= 1'b0;
      cfg_r.point_x   <= '0;
      cfg_r.point_y   <= '0;
      cfg_r.frame_w   <= SIDE_CFG_W'(640);
      cfg_r.frame_h   <= SIDE_CFG_W'(400);
      cfg_r.radius    <= RAD_W'(2);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- src/mpmd_ctrl.sv -----
`default_nettype none

module mpmd_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  input  wire                    in_tlast,
  output logic                   in_tready,
  input  mpmd_pkg::ctrl_sts_t    sts,
  output mpmd_pkg::ctrl_cmd_t    cmd
);
  import mpmd_pkg::*;

  typedef enum logic [2:0] {
    S_RUN   = 3'b001,  // streaming samples
    S_DRAIN = 3'b010,  // last sample being inserted
    S_SEEK  = 3'b100   // walking to the median
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_RUN: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
        if (in_tvalid && in_tlast) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.seek_clr = 1'b1;
        state_nxt    = S_SEEK;
      end
      S_SEEK: begin
        if (!sts.at_target) begin
          cmd.seek_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_RUN;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

// ----- src/mpmd_dp.sv -----
`default_nettype none

module mpmd_dp #(
  parameter int MAX_FRAME_SIDE = 4096
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  mpmd_pkg::cfg_t                      cfg,
  input  mpmd_pkg::ctrl_cmd_t                 cmd,
  output mpmd_pkg::ctrl_sts_t                 sts,
  input  wire  [mpmd_pkg::DEPTH_W-1:0]        in_depth,
  input  wire                                 in_last,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [mpmd_pkg::OUT_DATA_W-1:0]     out_data
);
  import mpmd_pkg::*;

  localparam int POS_W  = $clog2(MAX_FRAME_SIDE);
  localparam int SIDE_W = $clog2(MAX_FRAME_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W;
  localparam logic [CMP_W-1:0] SIDE_MAX = CMP_W'(MAX_FRAME_SIDE);
  localparam logic [RAD_W-1:0] RAD_MAX  = RAD_W'(MAX_PATCH_RADIUS);

  // ---- geometry ----
  logic [CMP_W-1:0] fw, fh, w, h, col, row, px, py, dc, dr, col_inc, row_inc;
  logic [RAD_W-1:0] rad;
  logic             in_frame, active, hit;

  logic [POS_W-1:0] col_r, col_nxt, row_r, row_nxt;

  always_comb begin
    fw  = CMP_W'(cfg.frame_w);
    fh  = CMP_W'(cfg.frame_h);
    w   = (fw == '0) ? CMP_W'(1) : ((fw > SIDE_MAX) ? SIDE_MAX : fw);
    h   = (fh == '0) ? CMP_W'(1) : ((fh > SIDE_MAX) ? SIDE_MAX : fh);
    rad = (cfg.radius > RAD_MAX) ? RAD_MAX : cfg.radius;
    px  = CMP_W'(cfg.point_x);
    py  = CMP_W'(cfg.point_y);
    col = CMP_W'(col_r);
    row = CMP_W'(row_r);
    in_frame = (px < w) && (py < h);
    active   = cfg.point_sel && in_frame;
    dc  = (col > px) ? (col - px) : (px - col);
    dr  = (row > py) ? (row - py) : (py - row);
    hit = active && (in_depth != '0) && (row < h) && (col < w) &&
          (dc <= CMP_W'(rad)) && (dr <= CMP_W'(rad));

    col_inc = col + CMP_W'(1);
    row_inc = row + CMP_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.take) begin
      if (in_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= SIDE_MAX) ? '0 : row_inc[POS_W-1:0];
      end else begin
        col_nxt = col_inc[POS_W-1:0];
      end
    end
  end

  // ---- stage 1: accepted sample headed for the store ----
  logic               s1_hit_r;
  logic [DEPTH_W-1:0] s1_depth_r;

  // ---- sorted store: a row of compare-and-shift cells ----
  logic [DEPTH_W-1:0]     cell_r   [STORE_DEPTH];
  logic [DEPTH_W-1:0]     cell_nxt [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] gt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   ins;

  always_comb begin
    ins = s1_hit_r && (cnt_r < CNT_W'(STORE_DEPTH));
    for (int i = 0; i < STORE_DEPTH; i++) begin
      // cells at and above the fill count act as holding +infinity
      gt[i]       = (CNT_W'(i) >= cnt_r) || (cell_r[i] > s1_depth_r);
      cell_nxt[i] = cell_r[i];
    end
    if (cmd.seek_step) begin
      for (int i = 0; i < STORE_DEPTH - 1; i++) cell_nxt[i] = cell_r[i+1];
    end else if (ins) begin
      if (gt[0]) cell_nxt[0] = s1_depth_r;
      for (int i = 1; i < STORE_DEPTH; i++) begin
        if (CNT_W'(i) <= cnt_r && gt[i])
          cell_nxt[i] = gt[i-1] ? cell_r[i-1] : s1_depth_r;
      end
    end
    cnt_nxt = cnt_r;
    if (cmd.out_load) cnt_nxt = '0;
    else if (ins)     cnt_nxt = cnt_r + CNT_W'(1);
  end

  // ---- median seek: drop the lowest (n-1)/2 samples ----
  logic [IDX_W-1:0] seek_r, seek_nxt, tgt;
  logic [CNT_W-1:0] cnt_m1;

  always_comb begin
    cnt_m1   = cnt_r - CNT_W'(1);
    tgt      = (cnt_r == '0) ? '0 : IDX_W'(cnt_m1 >> 1);
    seek_nxt = seek_r;
    if (cmd.seek_clr)       seek_nxt = '0;
    else if (cmd.seek_step) seek_nxt = seek_r + IDX_W'(1);
  end

  // ---- result ----
  logic [STAT_W-1:0] stat;
  logic [MED_W-1:0]  med;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_comb begin
    med = '0;
    if (!cfg.point_sel)    stat = ST_NO_POINT;
    else if (!in_frame)    stat = ST_OUTSIDE;
    else if (cnt_r == '0)  stat = ST_NO_DEPTH;
    else begin
      stat = ST_OK;
      med  = cnt_r[0] ? {cell_r[0], 1'b0}
                      : (MED_W'(cell_r[0]) + MED_W'(cell_r[1]));
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign sts.at_target = (seek_r == tgt);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_hit_r    <= 1'b0;
      cnt_r       <= '0;
      seek_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_hit_r    <= cmd.take && hit;
      cnt_r       <= cnt_nxt;
      seek_r      <= seek_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) s1_depth_r <= in_depth;
    if (cmd.out_load) out_data_r <= {CNT_W'(cnt_r), med, stat};
    for (int i = 0; i < STORE_DEPTH; i++) cell_r[i] <= cell_nxt[i];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- src/masked_patch_median_depth.sv -----
`default_nettype none

// Channel  Dir  Ports                      Word
// -------  ---  -------------------------  ------------------------------------------
// in       in   in_tvalid/tready/tdata/    depth_sample in tdata, last_of_frame = tlast
//               tlast
// out      out  out_tvalid/tready/tdata    status, median_twice, valid_count
// cfg      in   cfg_we/cfg_index/cfg_wdata one register write per cycle with cfg_we
//
// During a frame one sample word is taken every cycle.
// After the last word of a frame the input stalls while the last sample is
// inserted, the sorted cell row is walked down past the lowest (n-1)/2 of the n
// kept samples to the median, and the result is loaded; it stalls longer only if
// the previous result word has not yet been taken. The result register lets the
// next frame stream in while a result waits. rst_n is synchronous, active low; it
// clears counters, count and control, and loads the register defaults.
module masked_patch_median_depth #(
  parameter int MAX_FRAME_SIDE = 4096
) (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [15:0] depth_sample
  input  wire         in_tlast,   // last_of_frame
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [1:0] status, [18:2] median_twice, [23:19] valid_count
  // register writes
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [12:0] cfg_wdata
);
  import mpmd_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mpmd_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer: stream, drain the last insert, seek the median, emit
  mpmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // raster counters, patch test, sorted cell row, result register
  mpmd_dp #(
    .MAX_FRAME_SIDE (MAX_FRAME_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_depth  (in_tdata),
    .in_last   (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mpmd_pkg::*;

  localparam int FRAME_SIDE_MAX = 4096;
  localparam int STALL_MAX      = 13;    // longest idle draw on either side
  localparam int SETTLE_CYCLES  = 24;    // longer than the worst median walk, plus margin
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on any side
  localparam int RANDOM_WORDS   = 1820;

  // Indexes past the register map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // Result word as it sits on out_tdata (last field in the low bits)
  typedef struct packed {
    logic [CNT_W-1:0]  valid_count;
    logic [MED_W-1:0]  median_twice;
    logic [STAT_W-1:0] status;
  } depth_result_t;

  // Tracks registers, raster position and the sorted patch samples, and
  // holds the result words still owed by the block.
  class patch_median_tracker;
    bit                  point_sel;
    bit [COORD_W-1:0]    point_x, point_y;
    bit [SIDE_CFG_W-1:0] frame_w, frame_h;
    bit [RAD_W-1:0]      radius;
    int unsigned         col, row, kept;
    bit [DEPTH_W-1:0]    sorted[STORE_DEPTH];
    depth_result_t       medians_due[$];
    int unsigned         mismatches;
    int unsigned         status_seen[4];

    function new();
      point_sel = 1'b0;
      point_x   = '0;
      point_y   = '0;
      frame_w   = 13'd640;
      frame_h   = 13'd400;
      radius    = 2'd2;
      col       = 0;
      row       = 0;
      kept      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_POINT_SEL: point_sel = val[0];
        REG_POINT_X:   point_x   = val[COORD_W-1:0];
        REG_POINT_Y:   point_y   = val[COORD_W-1:0];
        REG_FRAME_W:   frame_w   = val[SIDE_CFG_W-1:0];
        REG_FRAME_H:   frame_h   = val[SIDE_CFG_W-1:0];
        REG_RADIUS:    radius    = val[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_side(bit [SIDE_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > FRAME_SIDE_MAX) return FRAME_SIDE_MAX;
      return v;
    endfunction

    function int unsigned span(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void take_sample(logic [DEPTH_W-1:0] d, logic last);
      int unsigned   w, h, r, i;
      bit            in_frame;
      depth_result_t res;
      w = clamp_side(frame_w);
      h = clamp_side(frame_h);
      r = (radius > MAX_PATCH_RADIUS) ? MAX_PATCH_RADIUS : radius;
      in_frame = (point_x < w) && (point_y < h);
      if (point_sel && in_frame && d != 0 && row < h && col < w &&
          span(col, point_x) <= r && span(row, point_y) <= r &&
          kept < STORE_DEPTH) begin
        i = kept;
        while (i > 0 && sorted[i-1] > d) begin
          sorted[i] = sorted[i-1];
          i--;
        end
        sorted[i] = d;
        kept++;
      end
      if (!last) begin
        col++;
        if (col >= w) begin
          col = 0;
          row++;
          if (row >= FRAME_SIDE_MAX) row = 0;
        end
        return;
      end
      res = '0;
      if (!point_sel)
        res.status = ST_NO_POINT;
      else if (!in_frame)
        res.status = ST_OUTSIDE;
      else if (kept == 0)
        res.status = ST_NO_DEPTH;
      else begin
        res.status = ST_OK;
        if (kept % 2 == 1)
          res.median_twice = {sorted[kept/2], 1'b0};
        else
          res.median_twice = MED_W'(sorted[kept/2-1]) + MED_W'(sorted[kept/2]);
      end
      res.valid_count = CNT_W'(kept);
      medians_due = {medians_due, res};
      col  = 0;
      row  = 0;
      kept = 0;
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] word);
      depth_result_t got, want;
      got = word;
      if (medians_due.size() == 0) begin
        $error("result word %h arrived with no frame pending", word);
        mismatches++;
        return;
      end
      want = medians_due.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.median_twice !== want.median_twice) begin
        $error("median_twice: expected %0d, got %0d", want.median_twice, got.median_twice);
        mismatches++;
      end
      if (got.valid_count !== want.valid_count) begin
        $error("valid_count: expected %0d, got %0d", want.valid_count, got.valid_count);
        mismatches++;
      end
    endfunction
  endclass

  // Clock and DUT-facing signals; the ones the bench drives are known from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [DEPTH_W-1:0]    in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  patch_median_tracker tracker = new();

  // Gap switches: when clear, that side streams with no idle cycles
  bit          in_gaps  = 1'b1;
  bit          out_gaps = 1'b1;
  int unsigned words_sent, random_words, results_taken, quiet_cycles;
  int unsigned cur_w, cur_h;  // effective frame size of the random setup

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  masked_patch_median_depth #(
    .MAX_FRAME_SIDE(FRAME_SIDE_MAX)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Watchdog: any accepted word on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side: random stall before each word, then hold tready until one lands
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      stall = out_gaps ? $urandom_range(0, STALL_MAX) : 0;
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_word(out_tdata);
      results_taken++;
      @(negedge clk);
    end
  end

  // Mix of no-depth holes, saturated depth, tiny values (ties) and full-range noise.
  // Dense frames never send a zero, so the patch store can be filled.
  function automatic logic [DEPTH_W-1:0] pick_depth(bit dense);
    int unsigned k;
    k = $urandom_range(0, 7);
    if (k < 2 && !dense) return '0;
    if (k == 2) return '1;
    if (k == 3) return 16'd1;
    if (k == 4) return DEPTH_W'($urandom_range(1, 8));
    return DEPTH_W'($urandom_range(1, 65535));
  endfunction

  // Entered and left at a falling edge. tvalid stays high across back-to-back words.
  task automatic send_word(input logic [DEPTH_W-1:0] d, input logic l);
    int unsigned gap;
    gap = in_gaps ? $urandom_range(0, STALL_MAX) : 0;
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = d;
    in_tlast  = l;
    do @(posedge clk); while (!in_tready);
    tracker.take_sample(d, l);
    words_sent++;
    @(negedge clk);
  endtask

  // Raster of n words; tlast rides on the final one
  task automatic send_frame(input int unsigned n, input bit dense);
    for (int unsigned k = 1; k <= n; k++) send_word(pick_depth(dense), k == n);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Hold the sender off until every owed result is out and the median walk is done
  task automatic drain();
    in_tvalid = 1'b0;
    while (tracker.medians_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random setup for the next run of frames: small rasters, point mostly
  // inside, sometimes just past the edge or anywhere in the coordinate range.
  task automatic new_setup();
    int unsigned w, h;
    w = $urandom_range(0, 10);
    h = $urandom_range(0, 8);
    cur_w = (w == 0) ? 1 : w;
    cur_h = (h == 0) ? 1 : h;
    write_reg(REG_FRAME_W, CFG_DATA_W'(w));
    write_reg(REG_FRAME_H, CFG_DATA_W'(h));
    write_reg(REG_POINT_SEL, CFG_DATA_W'($urandom_range(0, 7) != 0));
    case ($urandom_range(0, 7))
      0:       write_reg(REG_POINT_X, CFG_DATA_W'($urandom_range(0, 4095)));
      1:       write_reg(REG_POINT_X, CFG_DATA_W'(cur_w + $urandom_range(0, 2)));
      default: write_reg(REG_POINT_X, CFG_DATA_W'($urandom_range(0, cur_w - 1)));
    endcase
    case ($urandom_range(0, 7))
      0:       write_reg(REG_POINT_Y, CFG_DATA_W'($urandom_range(0, 4095)));
      1:       write_reg(REG_POINT_Y, CFG_DATA_W'(cur_h + $urandom_range(0, 2)));
      default: write_reg(REG_POINT_Y, CFG_DATA_W'($urandom_range(0, cur_h - 1)));
    endcase
    write_reg(REG_RADIUS, CFG_DATA_W'($urandom_range(0, 3)));
    if ($urandom_range(0, 7) == 0)
      write_reg(REG_SPARE_6, CFG_DATA_W'($urandom_range(0, 8191)));
  endtask

  initial begin
    logic [DEPTH_W-1:0] grid[9];
    int unsigned        n;

    // Reset held from time zero, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- Directed ----
    // Power-on registers: no point chosen
    send_frame(3, 1'b0);
    drain();

    // 3x3 frame, point in the middle, radius 1: whole frame is the patch.
    // One hole leaves 8 samples, so the even-count average path; both depth
    // extremes and a duplicate pair land in the middle.
    write_reg(REG_POINT_SEL, 1);
    write_reg(REG_POINT_X, 1);
    write_reg(REG_POINT_Y, 1);
    write_reg(REG_FRAME_W, 3);
    write_reg(REG_FRAME_H, 3);
    write_reg(REG_RADIUS, 1);
    write_reg(REG_SPARE_6, 13'h1fff);  // off the map: ignored
    write_reg(REG_SPARE_7, 13'h0aaa);
    grid = '{16'd1, 16'hffff, 16'd0, 16'd700, 16'd700, 16'h8000, 16'd2, 16'hfffe, 16'd5};
    foreach (grid[k]) send_word(grid[k], k == 8);
    drain();

    // Point right of the frame: outside wins, single-word frame
    write_reg(REG_POINT_X, 5);
    send_frame(1, 1'b0);
    drain();

    // Point back inside, patch all holes: no valid depth
    write_reg(REG_POINT_X, 1);
    for (int k = 0; k < 5; k++) send_word('0, k == 4);
    drain();

    // Width 0 acts as 1, oversize height clamps, radius 3 saturates to 2.
    // One column, point on row 2: rows 0..4 are kept, rows 5..6 are not.
    write_reg(REG_FRAME_W, 0);
    write_reg(REG_FRAME_H, 13'h1fff);
    write_reg(REG_POINT_X, 0);
    write_reg(REG_POINT_Y, 2);
    write_reg(REG_RADIUS, 3);
    send_frame(7, 1'b1);
    drain();

    // ---- No idle cycles ----
    in_gaps  = 1'b0;
    out_gaps = 1'b0;

    // Oversize width clamps to the widest frame, so the last column is still
    // inside; a one-word frame never reaches the patch: no valid depth
    write_reg(REG_FRAME_W, 13'h1fff);
    write_reg(REG_FRAME_H, FRAME_SIDE_MAX);
    write_reg(REG_POINT_X, FRAME_SIDE_MAX - 1);
    write_reg(REG_POINT_Y, 0);
    write_reg(REG_RADIUS, 2);
    send_frame(1, 1'b0);
    drain();

    // ---- Random frames ----
    // Mostly whole rasters; some cut short, some running rows past the height.
    // A new setup is loaded between frames now and then, after a full drain;
    // otherwise frames go back to back while the last result may still wait.
    n = 0;
    while (random_words < RANDOM_WORDS) begin
      if (random_words == 0 || $urandom_range(0, 2) == 0) begin
        drain();
        new_setup();
      end
      in_gaps  = $urandom_range(0, 3) != 0;
      out_gaps = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 7))
        0:       n = $urandom_range(1, cur_w * cur_h);
        1:       n = cur_w * (cur_h + $urandom_range(1, 3));
        default: n = cur_w * cur_h;
      endcase
      send_frame(n, $urandom_range(0, 3) == 0);
      random_words += n;
    end

    drain();
    $display("Streamed %0d depth words (%0d in random frames), checked %0d result words.",
             words_sent, random_words, results_taken);
    $display("Results by status: ok %0d, no point %0d, outside %0d, no depth %0d.",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_NO_POINT],
             tracker.status_seen[ST_OUTSIDE], tracker.status_seen[ST_NO_DEPTH]);
    if (tracker.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
